// ----- design/pol_pkg.sv -----
// Shared types and constants for the positional ordered list.
// Used by pol_ctrl, pol_dp and positional_ordered_list. No dependencies.
`timescale 1ns / 1ps

package pol_pkg;

  // Storage size and the widths that follow from it.
  localparam int CAPACITY  = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  // A dump reports at most this many entries.
  localparam int DUMP_LIM  = (CAPACITY > 32) ? 32 : CAPACITY;
  // Common width for comparing a position against a count.
  localparam int CMP_W     = 7;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_pend;   // capture the incoming command
    logic exec;        // carry out a single-result command and fill the output register
    logic dump_start;  // clear the dump index
    logic dump_emit;   // report the entry at the dump index and advance it
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e pend_cmd;    // command waiting in the input register
    logic count_zero;  // list holds no entries
    logic dump_last;   // dump index points at the final entry to report
  } sts_t;

endpackage

// ----- design/pol_ctrl.sv -----
// Controller for the positional ordered list: input and output valid flags
// and the dump sequencer. Depends on pol_pkg.
`timescale 1ns / 1ps

module pol_ctrl import pol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;
  logic   pend_valid_q, pend_valid_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   emit;

  // The output register can take a new result when empty or being drained.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = pend_valid_q;
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d          = state_q;
    pend_valid_d     = pend_valid_q;
    ctl_o            = '0;
    ctl_o.load_pend  = in_valid_i && !pend_valid_q;
    if (ctl_o.load_pend) begin
      pend_valid_d = 1'b1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (pend_valid_q && out_free) begin
          if (sts_i.pend_cmd == CMD_DUMP && !sts_i.count_zero) begin
            ctl_o.dump_start = 1'b1;
            state_d          = S_DUMP;
          end else begin
            ctl_o.exec   = 1'b1;
            pend_valid_d = 1'b0;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctl_o.dump_emit = 1'b1;
          if (sts_i.dump_last) begin
            state_d      = S_IDLE;
            pend_valid_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid follows each result written and each transfer taken.
  assign emit = ctl_o.exec || ctl_o.dump_emit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

endmodule

// ----- design/pol_dp.sv -----
// Datapath for the positional ordered list: input register, register cells
// that shift in parallel, entry count, dump index and output register.
// Depends on pol_pkg.
`timescale 1ns / 1ps

module pol_dp import pol_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] value_i,
  input  logic [5:0]         position_i,
  input  ctl_t               ctl_i,
  output sts_t               sts_o,
  output logic signed [31:0] item_value_o,
  output logic [4:0]         item_index_o,
  output logic [5:0]         entry_count_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  // Input register.
  cmd_e               cmd_q;
  logic signed [31:0] value_q;
  logic [5:0]         pos_q;

  // List storage and control state.
  logic [31:0]        cells_q [CAPACITY];
  logic [31:0]        cells_d [CAPACITY];
  logic [31:0]        shl     [CAPACITY];
  logic [31:0]        shr     [CAPACITY];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   dump_idx_q;
  logic [CNT_W-1:0]   dump_len;

  // Output register.
  logic signed [31:0] item_value_q;
  logic [4:0]         item_index_q;
  logic [5:0]         entry_count_q;
  status_e            status_q;
  logic               last_q;

  logic [CMP_W-1:0]   cnt_x, pos_x, ins_pos;
  logic               full, ins_bad, del_bad, write_ok;
  logic [IDX_W-1:0]   pos_idx;
  logic signed [31:0] exec_value;
  logic [4:0]         exec_index;
  status_e            exec_status;

  // Capture a command on its transfer.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_pend) begin
      cmd_q   <= cmd_e'(cmd_i);
      value_q <= value_i;
      pos_q   <= position_i;
    end
  end

  // Checks on the pending command.
  assign cnt_x   = CMP_W'(count_q);
  assign pos_x   = CMP_W'(pos_q);
  assign pos_idx = IDX_W'(pos_q);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign ins_pos = (cmd_q == CMD_APPEND) ? cnt_x : pos_x;
  assign ins_bad = (ins_pos > cnt_x);
  assign del_bad = (pos_x >= cnt_x);

  // The list shifted up by one with the new value at the bottom, and shifted down by one.
  always_comb begin
    shl[0]          = value_q;
    shr[CAPACITY-1] = cells_q[CAPACITY-1];
    for (int k = 1; k < CAPACITY; k++) begin
      shl[k]   = cells_q[k-1];
      shr[k-1] = cells_q[k];
    end
  end

  // Result and next contents of a single-result command.
  always_comb begin
    exec_value  = '0;
    exec_index  = '0;
    exec_status = ST_OK;
    count_d     = count_q;
    write_ok    = 1'b0;
    cells_d     = cells_q;
    case (cmd_q)
      CMD_APPEND, CMD_INSERT: begin
        if (full) begin
          exec_status = ST_FULL;
        end else if (ins_bad) begin
          exec_status = ST_BADPOS;
        end else begin
          write_ok = 1'b1;
          count_d  = count_q + CNT_W'(1);
          for (int k = 0; k < CAPACITY; k++) begin
            if (CMP_W'(k) > ins_pos) begin
              cells_d[k] = shl[k];
            end else if (CMP_W'(k) == ins_pos) begin
              cells_d[k] = value_q;
            end
          end
        end
      end
      CMD_DELETE: begin
        if (del_bad) begin
          exec_status = ST_BADPOS;
        end else begin
          write_ok   = 1'b1;
          count_d    = count_q - CNT_W'(1);
          exec_value = cells_q[pos_idx];
          exec_index = 5'(pos_q);
          for (int k = 0; k < CAPACITY; k++) begin
            if (CMP_W'(k) >= pos_x) begin
              cells_d[k] = shr[k];
            end
          end
        end
      end
      default: begin
        // Only a dump of an empty list reaches here.
        exec_status = ST_EMPTY;
      end
    endcase
  end

  // Register cells move together.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && write_ok) begin
      cells_q <= cells_d;
    end
  end

  // Entry count and dump index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      dump_idx_q <= '0;
    end else begin
      if (ctl_i.exec) begin
        count_q <= count_d;
      end
      if (ctl_i.dump_start) begin
        dump_idx_q <= '0;
      end else if (ctl_i.dump_emit) begin
        dump_idx_q <= dump_idx_q + IDX_W'(1);
      end
    end
  end

  // A dump reports every entry, up to the dump limit.
  assign dump_len = (count_q > CNT_W'(DUMP_LIM)) ? CNT_W'(DUMP_LIM) : count_q;

  always_comb begin
    sts_o            = '0;
    sts_o.pend_cmd   = cmd_q;
    sts_o.count_zero = (count_q == '0);
    sts_o.dump_last  = ((CMP_W'(dump_idx_q) + CMP_W'(1)) == CMP_W'(dump_len));
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      item_value_q  <= exec_value;
      item_index_q  <= exec_index;
      entry_count_q <= 6'(count_d);
      status_q      <= exec_status;
      last_q        <= 1'b1;
    end else if (ctl_i.dump_emit) begin
      item_value_q  <= cells_q[dump_idx_q];
      item_index_q  <= 5'(dump_idx_q);
      entry_count_q <= 6'(count_q);
      status_q      <= ST_OK;
      last_q        <= sts_o.dump_last;
    end
  end

  assign item_value_o  = item_value_q;
  assign item_index_o  = item_index_q;
  assign entry_count_o = entry_count_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

endmodule

// ----- design/positional_ordered_list.sv -----
// Top level of the positional ordered list: joins controller and datapath.
// Depends on pol_pkg, pol_ctrl and pol_dp.
//
//   Channel  Handshake                  Payload
//   input    in_valid_i / in_stall_o    cmd_i, value_i, position_i
//   output   out_valid_o / out_stall_i  item_value_o, item_index_o, entry_count_o,
//                                       status_o, last_o
//
// Append, insert and delete each update the register cells, which shift in parallel,
// all at once; the input register stays full, and the input stalled, in the cycle
// that carries such a command out. A dump clears the dump index, then reports the
// entries, one result a cycle while the output is not stalled, as the dump index
// steps through the cells; no new command starts meanwhile.
// One command waits in an input register, so a transfer is taken while a result waits.
// Reset clears the entry count and the valid flags; the cells need no clearing.
// A stalled output holds its result and the pending command waits.
`timescale 1ns / 1ps

module positional_ordered_list import pol_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] value_i,
  input  logic [5:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] item_value_o,
  output logic [4:0]         item_index_o,
  output logic [5:0]         entry_count_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  ctl_t ctl;
  sts_t sts;

  // Controller.
  pol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Datapath.
  pol_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .item_value_o  (item_value_o),
    .item_index_o  (item_index_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule
